// File: rtl/core/rce_pkg.sv
// Shared types and constants of the rotor cipher encoder.
// Field widths, opcodes, register indexes, controller states and the
// command and status groups between controller and datapath.
package rce_pkg;

    localparam int SYM_W     = 7;
    localparam int OPC_W     = 2;
    localparam int SEL_W     = 3;
    localparam int NROT_W    = 4;
    localparam int COUNT_W   = 12;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_ROTORS_DEF   = 8;
    localparam int SYMBOL_COUNT_DEF = 76;

    localparam logic [NROT_W-1:0]  NUM_ROTORS_RST = 4'd1;
    localparam logic [COUNT_W-1:0] ROT_STEP_RST   = 12'd10;

    typedef enum logic [OPC_W-1:0] {
        OP_ENCODE   = 2'd0,
        OP_WR_ENTRY = 2'd1,
        OP_WR_EXIT  = 2'd2,
        OP_WR_PLUG  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROTORS = 1'b0,
        CFG_ROT_STEP   = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENTRY,
        ST_EXIT,
        ST_PLUG,
        ST_ADV,
        ST_MOD
    } state_t;

    typedef struct packed {
        logic accept;
        logic entry_rd;
        logic exit_rd;
        logic a_from_exit;
        logic plug_rd;
        logic out_load;
        logic adv_rotor;
        logic mod_start;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_encode;
        logic out_free;
        logic step_zero;
        logic mod_done;
        logic rem_zero;
    } dp_status_t;

endpackage

// File: rtl/core/rce_mod.sv
// Bit-serial remainder unit: one restoring step per cycle over the
// advance count width. Uses rce_pkg for the count width.
module rce_mod (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rce_pkg::COUNT_W-1:0] dividend,
    input  logic [rce_pkg::COUNT_W-1:0] divisor,
    output logic                        done,
    output logic                        rem_zero
);

    localparam int W      = rce_pkg::COUNT_W;
    localparam int ITER_W = $clog2(W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [W-1:0]      rem_reg;
    logic [W-1:0]      dvd_reg;
    logic [W-1:0]      div_reg;

    logic [W:0]   trial;
    logic         fits;
    logic [W-1:0] rem_next;

    assign trial    = {rem_reg, dvd_reg[W-1]};
    assign fits     = trial >= {1'b0, div_reg};
    assign rem_next = fits ? W'(trial - {1'b0, div_reg}) : trial[W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= busy_reg && (iter_reg == ITER_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(W);
            end else if (busy_reg) begin
                iter_reg <= iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
        end
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// File: rtl/core/rce_datapath.sv
// Datapath of the rotor cipher encoder: wiring memories, plugboard,
// rotor offsets and counts, configuration registers and result register.
// Uses rce_pkg and the rce_mod remainder unit.
module rce_datapath #(
    parameter  int MAX_ROTORS   = rce_pkg::MAX_ROTORS_DEF,
    parameter  int SYMBOL_COUNT = rce_pkg::SYMBOL_COUNT_DEF,
    localparam int RIDX_W       = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1,
    localparam int CNT_W        = $clog2(MAX_ROTORS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [rce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rce_pkg::COUNT_W-1:0]   cfg_data,
    input  logic [rce_pkg::OPC_W-1:0]     s_opcode,
    input  logic [rce_pkg::SEL_W-1:0]     s_rotor_sel,
    input  logic [rce_pkg::SYM_W-1:0]     s_position,
    input  logic [rce_pkg::SYM_W-1:0]     s_symbol,
    input  logic                          s_last,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [rce_pkg::SYM_W-1:0]     m_cipher_symbol,
    input  rce_pkg::dp_cmd_t              cmd,
    input  logic [RIDX_W-1:0]             rotor,
    output rce_pkg::dp_status_t           status,
    output logic [CNT_W-1:0]              num_active
);

    localparam int SYM_W   = rce_pkg::SYM_W;
    localparam int COUNT_W = rce_pkg::COUNT_W;
    localparam int DEPTH   = MAX_ROTORS * SYMBOL_COUNT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PLUG_AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam logic [SYM_W:0] SC_EXT = (SYM_W + 1)'(SYMBOL_COUNT);

    function automatic logic [ADDR_W-1:0] mem_addr(
        input logic [RIDX_W-1:0] rot,
        input logic [SYM_W-1:0]  sym
    );
        return ADDR_W'(rot) * ADDR_W'(SYMBOL_COUNT) + ADDR_W'(sym);
    endfunction

    // symbol reduction table for encode input
    logic [SYM_W-1:0] sym_mod [2**SYM_W];
    for (genvar g = 0; g < 2**SYM_W; g++) begin : g_sym_mod
        assign sym_mod[g] = SYM_W'(g % SYMBOL_COUNT);
    end

    // configuration
    logic [rce_pkg::NROT_W-1:0] num_rotors_reg;
    logic [COUNT_W-1:0]         step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rotors_reg <= rce_pkg::NUM_ROTORS_RST;
            step_reg       <= rce_pkg::ROT_STEP_RST;
        end else if (cfg_valid) begin
            unique case (rce_pkg::cfg_index_t'(cfg_index))
                rce_pkg::CFG_NUM_ROTORS: num_rotors_reg <= cfg_data[rce_pkg::NROT_W-1:0];
                rce_pkg::CFG_ROT_STEP:   step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign num_active = (32'(num_rotors_reg) > MAX_ROTORS) ? CNT_W'(MAX_ROTORS)
                                                          : CNT_W'(num_rotors_reg);

    // write decode
    rce_pkg::opcode_t op_in;
    logic             pos_ok;
    logic             sym_ok;
    logic             sel_ok;
    logic             wr_ok;
    logic             entry_we;
    logic             exit_we;
    logic             plug_we;
    logic [RIDX_W-1:0] sel_idx;

    assign op_in    = rce_pkg::opcode_t'(s_opcode);
    assign pos_ok   = {1'b0, s_position} < SC_EXT;
    assign sym_ok   = {1'b0, s_symbol} < SC_EXT;
    assign sel_ok   = 32'(s_rotor_sel) < MAX_ROTORS;
    assign wr_ok    = cmd.accept && pos_ok && sym_ok;
    assign entry_we = wr_ok && sel_ok && (op_in == rce_pkg::OP_WR_ENTRY);
    assign exit_we  = wr_ok && sel_ok && (op_in == rce_pkg::OP_WR_EXIT);
    assign plug_we  = wr_ok && (op_in == rce_pkg::OP_WR_PLUG);
    assign sel_idx  = RIDX_W'(s_rotor_sel);

    // item in flight
    logic [SYM_W-1:0] a_reg;
    logic             last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            a_reg    <= sym_mod[s_symbol];
            last_reg <= s_last;
        end
    end

    // rotor state
    logic [SYM_W-1:0]   offset_reg [MAX_ROTORS];
    logic [COUNT_W-1:0] count_reg  [MAX_ROTORS];
    logic [SYM_W-1:0]   cur_off;
    logic [SYM_W:0]     off_inc;
    logic [SYM_W-1:0]   offset_next;
    logic [COUNT_W-1:0] count_next;
    logic [RIDX_W-1:0]  prev_idx;

    assign cur_off     = offset_reg[rotor];
    assign off_inc     = {1'b0, cur_off} + (SYM_W + 1)'(1);
    assign offset_next = (off_inc >= SC_EXT) ? '0 : off_inc[SYM_W-1:0];
    assign count_next  = count_reg[rotor] + COUNT_W'(1);
    assign prev_idx    = rotor - RIDX_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn || (cmd.finish && last_reg)) begin
            for (int i = 0; i < MAX_ROTORS; i++) begin
                offset_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end else if (cmd.adv_rotor) begin
            offset_reg[rotor] <= offset_next;
            count_reg[rotor]  <= count_next;
        end
    end

    // wiring memories
    logic [SYM_W-1:0]  a_sel;
    logic [SYM_W-1:0]  entry_mem [DEPTH];
    logic [SYM_W-1:0]  exit_mem  [DEPTH];
    logic [SYM_W-1:0]  entry_data_reg;
    logic [SYM_W-1:0]  exit_data_reg;
    logic [SYM_W:0]    p_sum;
    logic [SYM_W-1:0]  p_mod;

    assign a_sel = cmd.a_from_exit ? exit_data_reg : a_reg;

    always_ff @(posedge aclk) begin
        if (entry_we) begin
            entry_mem[mem_addr(sel_idx, s_symbol)] <= s_position;
        end
        if (cmd.entry_rd) begin
            entry_data_reg <= entry_mem[mem_addr(rotor, a_sel)];
        end
    end

    // contact position plus rotor offset, wrapped once
    assign p_sum = {1'b0, entry_data_reg} + {1'b0, cur_off};
    assign p_mod = (p_sum >= SC_EXT) ? SYM_W'(p_sum - SC_EXT) : p_sum[SYM_W-1:0];

    always_ff @(posedge aclk) begin
        if (exit_we) begin
            exit_mem[mem_addr(sel_idx, s_position)] <= s_symbol;
        end
        if (cmd.exit_rd) begin
            exit_data_reg <= exit_mem[mem_addr(rotor, p_mod)];
        end
    end

    // plugboard: unwritten entries read as the reversal mapping
    logic [SYM_W-1:0]        plug_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] plug_vld_reg;
    logic [SYM_W-1:0]        plug_data_reg;
    logic [SYM_W-1:0]        plug_addr_reg;
    logic                    plug_hit_reg;
    logic [PLUG_AW-1:0]      plug_raddr;
    logic [PLUG_AW-1:0]      plug_waddr;
    logic [SYM_W-1:0]        plug_value;

    assign plug_raddr = PLUG_AW'(a_sel);
    assign plug_waddr = PLUG_AW'(s_position);

    always_ff @(posedge aclk) begin
        if (plug_we) begin
            plug_mem[plug_waddr] <= s_symbol;
        end
        if (cmd.plug_rd) begin
            plug_data_reg <= plug_mem[plug_raddr];
            plug_hit_reg  <= plug_vld_reg[plug_raddr];
            plug_addr_reg <= a_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plug_vld_reg <= '0;
        end else if (plug_we) begin
            plug_vld_reg[plug_waddr] <= 1'b1;
        end
    end

    assign plug_value = plug_hit_reg ? plug_data_reg
                      : SYM_W'(SC_EXT - (SYM_W + 1)'(1) - {1'b0, plug_addr_reg});

    // result register
    logic             m_valid_reg;
    logic [SYM_W-1:0] cipher_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            cipher_reg <= plug_value;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cipher_symbol = cipher_reg;

    // carry test on the previous rotor's count
    logic mod_done;
    logic rem_zero;

    rce_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mod_start),
        .dividend (count_reg[prev_idx]),
        .divisor  (step_reg),
        .done     (mod_done),
        .rem_zero (rem_zero)
    );

    assign status.is_encode = (op_in == rce_pkg::OP_ENCODE);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.step_zero = (step_reg == '0);
    assign status.mod_done  = mod_done;
    assign status.rem_zero  = rem_zero;

endmodule

// File: rtl/core/rce_ctrl.sv
// Controller of the rotor cipher encoder: walks the rotor chain, the
// plugboard read and the stepping carry chain. Uses rce_pkg.
module rce_ctrl #(
    parameter  int MAX_ROTORS = rce_pkg::MAX_ROTORS_DEF,
    localparam int RIDX_W     = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1,
    localparam int CNT_W      = $clog2(MAX_ROTORS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rce_pkg::dp_status_t status,
    input  logic [CNT_W-1:0]    num_active,
    output rce_pkg::dp_cmd_t    cmd,
    output logic [RIDX_W-1:0]   rotor
);

    rce_pkg::state_t  state_reg;
    rce_pkg::state_t  state_next;
    logic [CNT_W-1:0] r_reg;
    logic [CNT_W-1:0] r_next;
    logic             at_end;

    assign at_end  = (r_reg == num_active);
    assign s_ready = (state_reg == rce_pkg::ST_IDLE);
    assign rotor   = RIDX_W'(r_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rce_pkg::ST_IDLE;
            r_reg     <= '0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        r_next     = r_reg;
        unique case (state_reg)
            rce_pkg::ST_IDLE: begin
                if (s_valid && status.is_encode) begin
                    state_next = rce_pkg::ST_ENTRY;
                    r_next     = '0;
                end
            end
            rce_pkg::ST_ENTRY: begin
                state_next = at_end ? rce_pkg::ST_PLUG : rce_pkg::ST_EXIT;
            end
            rce_pkg::ST_EXIT: begin
                state_next = rce_pkg::ST_ENTRY;
                r_next     = r_reg + CNT_W'(1);
            end
            rce_pkg::ST_PLUG: begin
                if (status.out_free) begin
                    state_next = rce_pkg::ST_ADV;
                    r_next     = '0;
                end
            end
            rce_pkg::ST_ADV: begin
                if (at_end) begin
                    state_next = rce_pkg::ST_IDLE;
                end else if (r_reg == '0) begin
                    r_next = r_reg + CNT_W'(1);
                end else if (status.step_zero) begin
                    state_next = rce_pkg::ST_IDLE;
                end else begin
                    state_next = rce_pkg::ST_MOD;
                end
            end
            rce_pkg::ST_MOD: begin
                if (status.mod_done) begin
                    if (status.rem_zero) begin
                        state_next = rce_pkg::ST_ADV;
                        r_next     = r_reg + CNT_W'(1);
                    end else begin
                        state_next = rce_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = rce_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            rce_pkg::ST_IDLE: begin
                cmd.accept = s_valid;
            end
            rce_pkg::ST_ENTRY: begin
                // first rotor takes the input symbol, later ones the previous exit
                cmd.a_from_exit = (r_reg != '0);
                if (at_end) begin
                    cmd.plug_rd = 1'b1;
                end else begin
                    cmd.entry_rd = 1'b1;
                end
            end
            rce_pkg::ST_EXIT: begin
                cmd.exit_rd = 1'b1;
            end
            rce_pkg::ST_PLUG: begin
                cmd.out_load = status.out_free;
            end
            rce_pkg::ST_ADV: begin
                if (at_end) begin
                    cmd.finish = 1'b1;
                end else if (r_reg == '0) begin
                    cmd.adv_rotor = 1'b1;
                end else if (status.step_zero) begin
                    cmd.finish = 1'b1;
                end else begin
                    cmd.mod_start = 1'b1;
                end
            end
            rce_pkg::ST_MOD: begin
                if (status.mod_done) begin
                    cmd.adv_rotor = status.rem_zero;
                    cmd.finish    = !status.rem_zero;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/rotor_cipher_encoder.sv
// Rotor cipher encoder over an alphabet of SYMBOL_COUNT symbols: write items
// load entry/exit wiring and the plugboard, encode items return one cipher
// symbol. A write item is taken without leaving the idle state. An encode
// item with N active rotors makes two wiring memory reads per rotor, then
// the plugboard read, result load and rotor 0 step, or only the plugboard
// read and result load with no active rotor; each later rotor whose carry
// is tested, until a failed test ends the stepping, adds a count-modulo-step
// test in a bit-serial remainder unit, one bit per cycle over the 12-bit
// count. The result load holds while the previous result still waits for
// m_ready. The next item is taken once stepping ends; a finished result may
// still wait in the output register meanwhile. Wiring reads of entries never
// written return unspecified data. Uses rce_pkg, rce_ctrl and rce_datapath.
module rotor_cipher_encoder #(
    parameter int MAX_ROTORS   = rce_pkg::MAX_ROTORS_DEF,
    parameter int SYMBOL_COUNT = rce_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rce_pkg::OPC_W-1:0]     s_opcode,
    input  logic [rce_pkg::SEL_W-1:0]     s_rotor_sel,
    input  logic [rce_pkg::SYM_W-1:0]     s_position,
    input  logic [rce_pkg::SYM_W-1:0]     s_symbol,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rce_pkg::SYM_W-1:0]     m_cipher_symbol,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rce_pkg::COUNT_W-1:0]   cfg_data
);

    localparam int RIDX_W = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROTORS + 1);

    rce_pkg::dp_cmd_t    cmd;
    rce_pkg::dp_status_t status;
    logic [RIDX_W-1:0]   rotor;
    logic [CNT_W-1:0]    num_active;

    // registers are plain flops, always writable
    assign cfg_ready = 1'b1;

    rce_ctrl #(
        .MAX_ROTORS (MAX_ROTORS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .status     (status),
        .num_active (num_active),
        .cmd        (cmd),
        .rotor      (rotor)
    );

    rce_datapath #(
        .MAX_ROTORS   (MAX_ROTORS),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_opcode        (s_opcode),
        .s_rotor_sel     (s_rotor_sel),
        .s_position      (s_position),
        .s_symbol        (s_symbol),
        .s_last          (s_last),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_cipher_symbol (m_cipher_symbol),
        .cmd             (cmd),
        .rotor           (rotor),
        .status          (status),
        .num_active      (num_active)
    );

endmodule

// File: tb/tb_rotor_cipher_encoder.sv
// Self-checking testbench of rotor_cipher_encoder: directed table, then random
// messages under several rotor settings; wiring is loaded on demand before encodes.
// Depends on rce_pkg and the rotor_cipher_encoder RTL.
module tb_rotor_cipher_encoder;

    localparam int SYM_W    = rce_pkg::SYM_W;
    localparam int SEL_W    = rce_pkg::SEL_W;
    localparam int NROT_W   = rce_pkg::NROT_W;
    localparam int COUNT_W  = rce_pkg::COUNT_W;
    localparam int NSYM     = rce_pkg::SYMBOL_COUNT_DEF;
    localparam int MAX_R    = rce_pkg::MAX_ROTORS_DEF;
    localparam int SETTLE   = 2 * MAX_R + 5 + (MAX_R - 1) * 14 + 40;
    localparam int LIMIT    = 600_000;
    localparam int PHASES   = 7;
    localparam int ITEMS    = 700;
    localparam int DIR_ROWS = 32;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        rce_pkg::opcode_t    op;
        logic [SEL_W-1:0]    sel;
        logic [SYM_W-1:0]    pos;
        logic [SYM_W-1:0]    sym;
        logic                last;
        logic                typed;
        logic [SYM_W-1:0]    want;
        rce_pkg::cfg_index_t idx;
        logic [COUNT_W-1:0]  data;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    rce_pkg::opcode_t     s_opcode = rce_pkg::OP_ENCODE;
    logic [SEL_W-1:0]     s_rotor_sel = '0;
    logic [SYM_W-1:0]     s_position = '0;
    logic [SYM_W-1:0]     s_symbol = '0;
    logic                 s_last = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SYM_W-1:0]     m_cipher_symbol;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    rce_pkg::cfg_index_t  cfg_index = rce_pkg::CFG_NUM_ROTORS;
    logic [COUNT_W-1:0]   cfg_data = '0;

    // predictor state
    logic [SYM_W-1:0]     entry_tab [0:MAX_R-1][0:NSYM-1];
    logic [SYM_W-1:0]     exit_tab  [0:MAX_R-1][0:NSYM-1];
    bit                   entry_ok  [0:MAX_R-1][0:NSYM-1];
    bit                   exit_ok   [0:MAX_R-1][0:NSYM-1];
    logic [SYM_W-1:0]     plug_tab  [0:NSYM-1];
    int                   offs      [0:MAX_R-1];
    logic [COUNT_W-1:0]   cnt       [0:MAX_R-1];
    logic [NROT_W-1:0]    cfg_rotors = rce_pkg::NUM_ROTORS_RST;
    logic [COUNT_W-1:0]   cfg_step = rce_pkg::ROT_STEP_RST;

    logic [SYM_W-1:0]     cipher_q [$];
    int                   fail_cnt = 0;
    int                   cyc = 0;
    int                   sent = 0;
    bit                   idle_on = 1'b1;
    int                   ready_hold = 0;

    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{ROW_CFG,  rce_pkg::OP_ENCODE,   0,   0,   0, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 12'h0F0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,   0, 0, 1, 75, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,  75, 0, 1,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,  76, 0, 1, 75, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0, 127, 1, 1, 24, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_WR_PLUG,  0,  76,   5, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_WR_PLUG,  0,  10, 127, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_WR_PLUG,  0,  10,   3, 1, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,  10, 0, 1,  3, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,  65, 0, 1, 10, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_WR_ENTRY, 7, 100,   5, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_WR_EXIT,  7,  20, 127, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_CFG,  rce_pkg::OP_ENCODE,   0,   0,   0, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 1},
        '{ROW_CFG,  rce_pkg::OP_ENCODE,   0,   0,   0, 0, 0,  0, rce_pkg::CFG_ROT_STEP, 1},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,   0, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_CFG,  rce_pkg::OP_ENCODE,   0,   0,   0, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 8},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0, 127, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,  33, 1, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,  33, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_WR_ENTRY, 3,   5,  40, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_WR_ENTRY, 3,  75,  40, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_WR_EXIT,  3,  75,  75, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_CFG,  rce_pkg::OP_ENCODE,   0,   0,   0, 0, 0,  0, rce_pkg::CFG_ROT_STEP, 0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,  40, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,  40, 1, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_CFG,  rce_pkg::OP_ENCODE,   0,   0,   0, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 15},
        '{ROW_CFG,  rce_pkg::OP_ENCODE,   0,   0,   0, 0, 0,  0, rce_pkg::CFG_ROT_STEP, 4095},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,   1, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_CFG,  rce_pkg::OP_ENCODE,   0,   0,   0, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 9},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,  64, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_WR_PLUG,  0,  75,  75, 0, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0},
        '{ROW_ITEM, rce_pkg::OP_ENCODE,   0,   0,   0, 1, 0,  0, rce_pkg::CFG_NUM_ROTORS, 0}
    };

    int unsigned rot_plan  [0:PHASES-1] = '{1, 2, 8, 0, 15, 3, 8};
    int unsigned step_plan [0:PHASES-1] = '{4095, 1, 2, 0, 3, 1, 1};

    rotor_cipher_encoder i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_rotor_sel     (s_rotor_sel),
        .s_position      (s_position),
        .s_symbol        (s_symbol),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cipher_symbol (m_cipher_symbol),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT) begin
            $display("[rotor_cipher_encoder] ERROR");
            $finish;
        end
    end

    // Update the tables for a write item, or compute the cipher symbol of an encode item and update the rotor state.
    task automatic cipher_predict(input rce_pkg::opcode_t op, input logic [SEL_W-1:0] sel,
                                  input logic [SYM_W-1:0] pos, input logic [SYM_W-1:0] sym,
                                  input logic last, output bit has_res,
                                  output logic [SYM_W-1:0] res);
        int n;
        int a;
        int p;
        bit moved;
        has_res = 1'b0;
        res = '0;
        if (op != rce_pkg::OP_ENCODE) begin
            if (pos < NSYM && sym < NSYM) begin
                case (op)
                    rce_pkg::OP_WR_PLUG: plug_tab[pos] = sym;
                    rce_pkg::OP_WR_ENTRY: begin
                        entry_tab[sel][sym] = pos;
                        entry_ok[sel][sym]  = 1'b1;
                    end
                    default: begin
                        exit_tab[sel][pos] = sym;
                        exit_ok[sel][pos]  = 1'b1;
                    end
                endcase
            end
        end else begin
            n = (cfg_rotors > MAX_R) ? MAX_R : int'(cfg_rotors);
            a = sym % NSYM;
            for (int r = 0; r < n; r++) begin
                p = (int'(entry_tab[r][a]) + offs[r]) % NSYM;
                a = exit_tab[r][p] % NSYM;
            end
            a = plug_tab[a] % NSYM;
            moved = 1'b1;
            for (int r = 0; r < n; r++) begin
                if (r > 0)
                    moved = moved && cfg_step != 0 && (cnt[r-1] % cfg_step) == 0;
                if (moved) begin
                    offs[r] = (offs[r] + 1 >= NSYM) ? 0 : offs[r] + 1;
                    cnt[r] = cnt[r] + 1'b1;
                end
            end
            if (last) begin
                for (int r = 0; r < MAX_R; r++) begin
                    offs[r] = 0;
                    cnt[r] = '0;
                end
            end
            has_res = 1'b1;
            res = a[SYM_W-1:0];
        end
    endtask

    // Find the first wiring entry that an encode of sym would read unwritten.
    function automatic bit find_gap(input logic [SYM_W-1:0] sym, output bit is_exit,
                                    output int gap_rot, output int gap_idx);
        int n;
        int a;
        int p;
        is_exit = 1'b0;
        gap_rot = 0;
        gap_idx = 0;
        n = (cfg_rotors > MAX_R) ? MAX_R : int'(cfg_rotors);
        a = sym % NSYM;
        for (int r = 0; r < n; r++) begin
            if (!entry_ok[r][a]) begin
                gap_rot = r;
                gap_idx = a;
                return 1'b1;
            end
            p = (int'(entry_tab[r][a]) + offs[r]) % NSYM;
            if (!exit_ok[r][p]) begin
                is_exit = 1'b1;
                gap_rot = r;
                gap_idx = p;
                return 1'b1;
            end
            a = exit_tab[r][p] % NSYM;
        end
        return 1'b0;
    endfunction

    // Present one item, hold it until accepted, then record its expectation.
    task automatic send_item(input rce_pkg::opcode_t op, input logic [SEL_W-1:0] sel,
                             input logic [SYM_W-1:0] pos, input logic [SYM_W-1:0] sym,
                             input logic last, input bit typed,
                             input logic [SYM_W-1:0] want);
        bit has_res;
        logic [SYM_W-1:0] res;
        if (idle_on && $urandom_range(5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_rotor_sel <= sel;
        s_position  <= pos;
        s_symbol    <= sym;
        s_last      <= last;
        do @(posedge aclk); while (!s_ready);
        sent++;
        cipher_predict(op, sel, pos, sym, last, has_res, res);
        if (has_res)
            cipher_q = {cipher_q, (typed ? want : res)};
    endtask

    // Write every wiring entry that the coming encode of sym would read.
    task automatic fill_wiring(input logic [SYM_W-1:0] sym);
        bit is_exit;
        int gap_rot;
        int gap_idx;
        while (find_gap(sym, is_exit, gap_rot, gap_idx)) begin
            if (is_exit)
                send_item(rce_pkg::OP_WR_EXIT, SEL_W'(gap_rot), SYM_W'(gap_idx),
                          SYM_W'($urandom_range(NSYM - 1)), 1'($urandom), 1'b0, '0);
            else
                send_item(rce_pkg::OP_WR_ENTRY, SEL_W'(gap_rot),
                          SYM_W'($urandom_range(NSYM - 1)), SYM_W'(gap_idx),
                          1'($urandom), 1'b0, '0);
        end
    endtask

    task automatic push_item(input rce_pkg::opcode_t op, input logic [SEL_W-1:0] sel,
                             input logic [SYM_W-1:0] pos, input logic [SYM_W-1:0] sym,
                             input logic last, input bit typed,
                             input logic [SYM_W-1:0] want);
        if (op == rce_pkg::OP_ENCODE)
            fill_wiring(sym);
        send_item(op, sel, pos, sym, last, typed, want);
    endtask

    // Drop valid and hold off until every expected result has come.
    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (cipher_q.size() != 0);
    endtask

    task automatic settle_idle();
        wait_results();
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input rce_pkg::cfg_index_t idx, input logic [COUNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rce_pkg::CFG_NUM_ROTORS)
            cfg_rotors = val[NROT_W-1:0];
        else
            cfg_step = val;
    endtask

    task automatic random_item(inout int msg_left);
        int k;
        logic [SYM_W-1:0] sym;
        bit last;
        k = $urandom_range(99);
        if (k < 75) begin
            sym = ($urandom_range(9) == 0) ? 7'($urandom_range(76, 127))
                                           : 7'($urandom_range(NSYM - 1));
            msg_left--;
            last = (msg_left <= 0);
            if (last)
                msg_left = $urandom_range(1, 30);
            push_item(rce_pkg::OP_ENCODE, 3'($urandom), 7'($urandom), sym, last, 1'b0, '0);
        end else if (k < 90) begin
            push_item(rce_pkg::opcode_t'($urandom_range(1, 3)), 3'($urandom),
                      7'($urandom_range(NSYM - 1)), 7'($urandom_range(NSYM - 1)),
                      1'($urandom), 1'b0, '0);
        end else begin
            push_item(rce_pkg::opcode_t'($urandom_range(1, 3)), 3'($urandom), 7'($urandom),
                      7'($urandom), 1'($urandom), 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected cipher symbol %0d", $time, m_cipher_symbol);
                fail_cnt++;
            end else if (m_cipher_symbol !== cipher_q[0]) begin
                $display("%0t: cipher mismatch: expected %0d, actual %0d",
                         $time, cipher_q[0], m_cipher_symbol);
                fail_cnt++;
                void'(cipher_q.pop_front());
            end else begin
                void'(cipher_q.pop_front());
            end
        end
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(9) == 0) begin
            ready_hold <= $urandom_range(13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int msg_left;
        int phase_end;
        for (int s = 0; s < NSYM; s++)
            plug_tab[s] = 7'(NSYM - 1 - s);
        for (int r = 0; r < MAX_R; r++) begin
            offs[r] = 0;
            cnt[r] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                settle_idle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                push_item(dir_tab[i].op, dir_tab[i].sel, dir_tab[i].pos, dir_tab[i].sym,
                          dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle_idle();
            idle_on = !(ph == 2 || ph == PHASES - 1);
            write_reg(rce_pkg::CFG_NUM_ROTORS, {8'($urandom), 4'(rot_plan[ph])});
            write_reg(rce_pkg::CFG_ROT_STEP, 12'(step_plan[ph]));
            msg_left = $urandom_range(1, 30);
            phase_end = ITEMS * (ph + 1) / PHASES;
            for (int i = 0; sent < phase_end; i++) begin
                if (ph == 1 && i == 20)
                    wait_results();
                random_item(msg_left);
            end
        end

        wait_results();
        repeat (SETTLE) @(posedge aclk);
        if (fail_cnt == 0 && cipher_q.size() == 0) begin
            $display("[rotor_cipher_encoder] OK");
        end else begin
            $display("[rotor_cipher_encoder] ERROR");
        end
        $finish;
    end

endmodule
